>>> rtl/core/xbs_pkg.sv
// ----------------------------------------------------------------------------
// xbs_pkg
// Shared types, character constants and helpers for the XML byte sanitizer.
// ----------------------------------------------------------------------------
package xbs_pkg;

  // Character codes used by the sanitizer.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_DIG_0   = 8'h30;
  localparam logic [7:0] CH_DIG_9   = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_M   = 8'h6D;
  localparam logic [7:0] CH_LOW_P   = 8'h70;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;

  // The escape sequence "&amp;".
  localparam int ESC_LEN = 5;
  localparam int ESC_IW  = $clog2(ESC_LEN);

  // Input and result transactions.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } xbs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       stream_end;
  } xbs_out_t;

  // Where an emitted byte comes from.
  typedef enum logic [2:0] {
    SRC_ESC,
    SRC_HELD,
    SRC_SEMI,
    SRC_CHAR,
    SRC_BARE
  } xbs_src_t;

  // Classification of the incoming byte.
  typedef struct packed {
    logic is_ref;
    logic is_semi;
    logic is_amp;
    logic is_drop;
  } xbs_dec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  cap;
    logic                  hold_wr;
    logic                  emit;
    xbs_src_t              src;
    logic [ESC_IW-1:0]     esc_idx;
    logic                  run_last;
    logic                  stream_end;
  } xbs_cmd_t;

  // One character of the escape sequence.
  function automatic logic [7:0] esc_char(input logic [ESC_IW-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CH_AMP;
      3'd1:    ch = CH_LOW_A;
      3'd2:    ch = CH_LOW_M;
      3'd3:    ch = CH_LOW_P;
      3'd4:    ch = CH_SEMI;
      default: ch = CH_AMP;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/xbs_datapath.sv
// ----------------------------------------------------------------------------
// xbs_datapath
// Byte classification, held-reference store, captured byte and output register.
// ----------------------------------------------------------------------------
module xbs_datapath #(
  parameter int DEPTH = 9,
  parameter int IW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  xbs_pkg::xbs_in_t in_data,
  output xbs_pkg::xbs_dec_t in_dec,
  input  xbs_pkg::xbs_cmd_t cmd,
  input  logic [IW-1:0]    wr_idx,
  input  logic [IW-1:0]    rd_idx,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_stall,
  output xbs_pkg::xbs_out_t out_data
);
  import xbs_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] held_r [DEPTH];
  logic       out_valid_r;
  xbs_out_t   out_data_r;
  xbs_out_t   out_data_nxt;
  logic [7:0] c;

  // Classify the incoming byte.
  assign c = in_data.in_byte;
  always_comb begin
    in_dec.is_ref  = (c >= CH_DIG_0 && c <= CH_DIG_9) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                     (c >= CH_LOW_A && c <= CH_LOW_Z) || (c == CH_HASH);
    in_dec.is_semi = (c == CH_SEMI);
    in_dec.is_amp  = (c == CH_AMP);
    in_dec.is_drop = (c < CTRL_LIMIT) && (c != CH_TAB) && (c != CH_LF) && (c != CH_CR);
  end

  // Captured input byte and the bytes held after an ampersand.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      byte_r <= c;
    end
    if (cmd.hold_wr) begin
      held_r[wr_idx] <= c;
    end
  end

  // Select the byte of the next result.
  always_comb begin
    unique case (cmd.src)
      SRC_ESC:  out_data_nxt.out_byte = esc_char(cmd.esc_idx);
      SRC_HELD: out_data_nxt.out_byte = held_r[rd_idx];
      SRC_SEMI: out_data_nxt.out_byte = CH_SEMI;
      SRC_CHAR: out_data_nxt.out_byte = byte_r;
      SRC_BARE: out_data_nxt.out_byte = 8'h00;
      default:  out_data_nxt.out_byte = 8'h00;
    endcase
    out_data_nxt.has_byte   = (cmd.src != SRC_BARE);
    out_data_nxt.run_last   = cmd.run_last;
    out_data_nxt.stream_end = cmd.stream_end;
  end

  // Output register: loads whenever it is empty or being taken.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/xbs_ctrl.sv
// ----------------------------------------------------------------------------
// xbs_ctrl
// Reference-tracking state and the sequencer that orders each item's results.
// ----------------------------------------------------------------------------
module xbs_ctrl #(
  parameter int DEPTH     = 9,
  parameter int CW        = 4,
  parameter int IW        = 4,
  parameter int SHORT_MIN = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_last,
  input  xbs_pkg::xbs_dec_t in_dec,
  input  logic              slot_free,
  output xbs_pkg::xbs_cmd_t cmd,
  output logic [IW-1:0]     wr_idx,
  output logic [IW-1:0]     rd_idx
);
  import xbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_HELD,
    S_TAIL,
    S_BARE
  } state_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_ESC,
    K_AMP,
    K_SEMI,
    K_CHAR
  } kind_t;

  localparam logic [ESC_IW-1:0] ESC_TOP = ESC_IW'(ESC_LEN - 1);

  state_t            state_r, state_nxt;
  kind_t             first_r, first_nxt;
  kind_t             tail_r, tail_nxt;
  logic [CW-1:0]     hnum_r, hnum_nxt;
  logic [IW-1:0]     hidx_r, hidx_nxt;
  logic [ESC_IW-1:0] eidx_r, eidx_nxt;
  logic              last_r, last_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  logic          accept;
  logic          valid_ref, hold, flush, norm, norm_amp, norm_char, short_esc;
  kind_t         p_first, p_tail;
  logic [CW-1:0] p_hnum;
  logic          p_bare;
  logic          at_end, is_final, hlast;
  logic [ESC_IW-1:0] first_top, tail_top;

  assign accept   = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);

  // Decide what the accepted byte does to the held reference.
  always_comb begin
    valid_ref = pend_r && in_dec.is_semi && (cnt_r != '0);
    hold      = pend_r && in_dec.is_ref && (cnt_r < CW'(DEPTH));
    flush     = pend_r && !valid_ref && !hold;
    norm      = !pend_r || flush;
    norm_amp  = norm && in_dec.is_amp;
    norm_char = norm && !in_dec.is_drop && !in_dec.is_amp;
    short_esc = (cnt_r >= CW'(SHORT_MIN));

    // Leading part of the results.
    if (valid_ref) begin
      p_first = K_AMP;
    end else if (flush || (hold && in_last) || (norm_amp && in_last)) begin
      p_first = K_ESC;
    end else begin
      p_first = K_NONE;
    end

    // Number of held bytes replayed.
    if (valid_ref || flush) begin
      p_hnum = cnt_r;
    end else if (hold && in_last) begin
      p_hnum = cnt_r + CW'(1);
    end else begin
      p_hnum = '0;
    end

    // Trailing part of the results.
    if (valid_ref) begin
      p_tail = K_SEMI;
    end else if (norm_char) begin
      p_tail = K_CHAR;
    end else if (flush && in_dec.is_amp && in_last) begin
      p_tail = short_esc ? K_AMP : K_ESC;
    end else begin
      p_tail = K_NONE;
    end

    p_bare = in_last && (p_first == K_NONE) && (p_tail == K_NONE);

    // Reference state after this byte.
    if (hold && !in_last) begin
      pend_nxt = 1'b1;
      cnt_nxt  = cnt_r + CW'(1);
    end else if (norm_amp && !in_last) begin
      pend_nxt = 1'b1;
      cnt_nxt  = '0;
    end else begin
      pend_nxt = 1'b0;
      cnt_nxt  = '0;
    end
  end

  assign wr_idx = cnt_r[IW-1:0];
  assign rd_idx = hidx_r;

  assign first_top = (first_r == K_AMP) ? '0 : ESC_TOP;
  assign tail_top  = (tail_r == K_AMP) ? '0 : ESC_TOP;
  assign hlast     = (CW'(hidx_r) == (hnum_r - CW'(1)));

  // Sequencer: one result per cycle while the output register can take it.
  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    tail_nxt  = tail_r;
    hnum_nxt  = hnum_r;
    hidx_nxt  = hidx_r;
    eidx_nxt  = eidx_r;
    last_nxt  = last_r;
    at_end    = 1'b0;
    is_final  = 1'b0;

    cmd.cap     = accept;
    cmd.hold_wr = accept && hold;
    cmd.emit    = 1'b0;
    cmd.src     = SRC_BARE;
    cmd.esc_idx = eidx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          first_nxt = p_first;
          tail_nxt  = p_tail;
          hnum_nxt  = p_hnum;
          last_nxt  = in_last;
          hidx_nxt  = '0;
          eidx_nxt  = '0;
          if (p_first != K_NONE) begin
            state_nxt = S_FIRST;
          end else if (p_tail != K_NONE) begin
            state_nxt = S_TAIL;
          end else if (p_bare) begin
            state_nxt = S_BARE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIRST: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_ESC;
        at_end   = (eidx_r == first_top);
        is_final = at_end && (hnum_r == '0) && (tail_r == K_NONE);
        if (slot_free) begin
          if (at_end) begin
            eidx_nxt = '0;
            if (hnum_r != '0) begin
              state_nxt = S_HELD;
            end else if (tail_r != K_NONE) begin
              state_nxt = S_TAIL;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            eidx_nxt = eidx_r + ESC_IW'(1);
          end
        end
      end
      S_HELD: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_HELD;
        is_final = hlast && (tail_r == K_NONE);
        if (slot_free) begin
          if (hlast) begin
            hidx_nxt  = '0;
            state_nxt = (tail_r != K_NONE) ? S_TAIL : S_IDLE;
          end else begin
            hidx_nxt = hidx_r + IW'(1);
          end
        end
      end
      S_TAIL: begin
        cmd.emit = 1'b1;
        priority case (tail_r)
          K_SEMI:  cmd.src = SRC_SEMI;
          K_CHAR:  cmd.src = SRC_CHAR;
          default: cmd.src = SRC_ESC;
        endcase
        at_end   = (tail_r == K_SEMI) || (tail_r == K_CHAR) || (eidx_r == tail_top);
        is_final = at_end;
        if (slot_free) begin
          if (at_end) begin
            eidx_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            eidx_nxt = eidx_r + ESC_IW'(1);
          end
        end
      end
      S_BARE: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_BARE;
        is_final = 1'b1;
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    cmd.run_last   = is_final;
    cmd.stream_end = is_final && last_r;
  end

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= K_NONE;
      tail_r  <= K_NONE;
      hnum_r  <= '0;
      hidx_r  <= '0;
      eidx_r  <= '0;
      last_r  <= 1'b0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      tail_r  <= tail_nxt;
      hnum_r  <= hnum_nxt;
      hidx_r  <= hidx_nxt;
      eidx_r  <= eidx_nxt;
      last_r  <= last_nxt;
      if (accept) begin
        pend_r <= pend_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // The held count never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("held count beyond store depth");

  // Without a pending ampersand nothing is held.
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r |-> (cnt_r == '0))
    else $error("held bytes without a pending ampersand");

  // The final byte of a document leaves no reference pending.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> !pend_r)
    else $error("reference still pending after end of document");

  // Replaying held bytes only happens when some are held.
  a_held_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HELD) |-> (hnum_r != '0))
    else $error("held replay with an empty count");

endmodule

>>> rtl/core/xml_byte_sanitizer.sv
// ----------------------------------------------------------------------------
// xml_byte_sanitizer
// Streaming clean-up of XML bytes: drops stray control bytes and escapes
// ampersands that do not start a well-formed character or entity reference.
// ----------------------------------------------------------------------------
// Each input transaction is accepted while the block is idle and then
// produces its results one per cycle through a single output register,
// while that register can take them. A byte that is dropped, or held
// before the end of the document, gives no result byte; a byte passed
// straight through gives one; a flushed held reference gives its escape,
// the held bytes and any trailing escape. The sequencer loads one byte a
// cycle into the output register; the input is stalled while it runs, and
// a stall on the output channel holds it. A new item is accepted once its
// predecessor's last result has entered the output register.
module xml_byte_sanitizer #(
  parameter int MAX_REF_SPAN = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  xbs_pkg::xbs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output xbs_pkg::xbs_out_t out_data
);
  import xbs_pkg::*;

  localparam int HELD_DEPTH = MAX_REF_SPAN - 1;
  localparam int CNT_W      = $clog2(HELD_DEPTH + 1);
  localparam int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int SHORT_MIN  = (MAX_REF_SPAN > 4) ? MAX_REF_SPAN - 4 : 0;

  xbs_dec_t         in_dec;
  xbs_cmd_t         cmd;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             slot_free;

  // Controller: reference tracking and result sequencing.
  xbs_ctrl #(
    .DEPTH     (HELD_DEPTH),
    .CW        (CNT_W),
    .IW        (IDX_W),
    .SHORT_MIN (SHORT_MIN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_data.in_last),
    .in_dec    (in_dec),
    .slot_free (slot_free),
    .cmd       (cmd),
    .wr_idx    (wr_idx),
    .rd_idx    (rd_idx)
  );

  // Datapath: classification, held bytes and the output register.
  xbs_datapath #(
    .DEPTH (HELD_DEPTH),
    .IW    (IDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_dec    (in_dec),
    .cmd       (cmd),
    .wr_idx    (wr_idx),
    .rd_idx    (rd_idx),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
